// ===== sv/i2cram_pkg.sv =====
// Shared types and constants for the I2C register access master.
package i2cram_pkg;

   // Depth of the request and result queues
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Reset value of the phase length register
   localparam logic [15:0] TICKS_PER_PHASE_RESET = 16'd16;

   // Transfer direction codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // One request: a bus tick with its operands
   typedef struct packed {
      logic       start_req;
      logic       op;
      logic [6:0] device_id;
      logic [7:0] reg_addr;
      logic [7:0] wr_data;
      logic       sda_in;
   } req_item_type;

   // One result: pin levels and status for that tick
   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_oe;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
   } rsp_item_type;

endpackage

// ===== sv/i2cram_fifo.sv =====
// Small first-in first-out queue used for requests and results.
module i2cram_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             wr_fire, rd_fire;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_fire = push && !full;
   assign rd_fire = pop && !empty;
   assign rd_data = mem[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_fire) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_fire) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
         count_in = count_ff + 1'b1;
      end else if (rd_fire && !wr_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== sv/i2cram_seq.sv =====
// Bus sequencer: steps the pin sequence by one tick per request.
module i2cram_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [15:0]               csr_wr_data,
   input  logic                      in_empty,
   input  i2cram_pkg::req_item_type  in_item,
   input  logic                      out_full,
   output logic                      take,
   output i2cram_pkg::rsp_item_type  out_item
);
   import i2cram_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SHI, ST_SLO, ST_WLO, ST_WHI, ST_ALO, ST_AHI, ST_RPREP,
      ST_RLO, ST_RHI, ST_NLO, ST_NHI, ST_PA, ST_PB, ST_PC
   } step_type;

   step_type    step_ff, step_in;
   logic [3:0]  bit_cnt_ff, bit_cnt_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [7:0]  tx_ff, tx_in;
   logic [7:0]  rx_ff, rx_in;
   logic [15:0] tick_ff, tick_in;
   logic        lat_op_ff, lat_op_in;
   logic [6:0]  lat_dev_ff, lat_dev_in;
   logic [7:0]  lat_reg_ff, lat_reg_in;
   logic [7:0]  lat_data_ff, lat_data_in;
   logic [15:0] period_ff;

   logic [15:0] period;
   logic [2:0]  pins;
   logic        busy, done, bit_msb;
   logic [7:0]  next_byte;

   assign take   = !in_empty && !out_full;
   assign period = (period_ff == '0) ? 16'd1 : period_ff;

   // Byte to send for a given index of the transfer
   function automatic logic [7:0] byte_for(input logic [1:0] idx, input logic is_read,
                                           input logic [6:0] dev, input logic [7:0] ra,
                                           input logic [7:0] wd);
      logic [7:0] b;
      if (idx == 2'd0) begin
         b = {dev, OP_WRITE};
      end else if (idx == 2'd1) begin
         b = ra;
      end else if (is_read) begin
         b = {dev, OP_READ};
      end else begin
         b = wd;
      end
      return b;
   endfunction

   // Tick logic: latch, drive pins, then advance at end of step
   always_comb begin
      step_in     = step_ff;
      bit_cnt_in  = bit_cnt_ff;
      byte_idx_in = byte_idx_ff;
      tx_in       = tx_ff;
      rx_in       = rx_ff;
      tick_in     = tick_ff;
      lat_op_in   = lat_op_ff;
      lat_dev_in  = lat_dev_ff;
      lat_reg_in  = lat_reg_ff;
      lat_data_in = lat_data_ff;
      done        = 1'b0;
      next_byte   = '0;

      // New transfer while idle: this tick is already the first start step
      if (step_ff == ST_IDLE && in_item.start_req) begin
         lat_op_in   = in_item.op;
         lat_dev_in  = in_item.device_id;
         lat_reg_in  = in_item.reg_addr;
         lat_data_in = in_item.wr_data;
         step_in     = ST_SHI;
         tick_in     = '0;
         byte_idx_in = '0;
         bit_cnt_in  = '0;
      end

      busy    = (step_in != ST_IDLE);
      bit_msb = tx_ff[7];

      // Pin levels {scl, sda_out, sda_oe} for the current step
      case (step_in)
         ST_SHI:   pins = 3'b111;
         ST_SLO:   pins = 3'b101;
         ST_WLO:   pins = {1'b0, bit_msb, 1'b1};
         ST_WHI:   pins = {1'b1, bit_msb, 1'b1};
         ST_ALO:   pins = 3'b010;
         ST_AHI:   pins = 3'b110;
         ST_RPREP: pins = 3'b011;
         ST_RLO:   pins = 3'b010;
         ST_RHI:   pins = 3'b110;
         ST_NLO:   pins = 3'b011;
         ST_NHI:   pins = 3'b111;
         ST_PA:    pins = 3'b001;
         ST_PB:    pins = 3'b101;
         ST_PC:    pins = 3'b111;
         default:  pins = 3'b111;
      endcase

      // Phase timer and step advance
      if (busy) begin
         if (({1'b0, tick_in} + 17'd1) >= {1'b0, period}) begin
            tick_in = '0;
            case (step_in)
               ST_SHI: step_in = ST_SLO;
               ST_SLO: begin
                  tx_in      = byte_for(byte_idx_in, lat_op_in, lat_dev_in, lat_reg_in,
                                        lat_data_in);
                  bit_cnt_in = '0;
                  step_in    = ST_WLO;
               end
               ST_WLO: step_in = ST_WHI;
               ST_WHI: begin
                  tx_in      = {tx_in[6:0], 1'b0};
                  bit_cnt_in = bit_cnt_in + 1'b1;
                  step_in    = (bit_cnt_in >= 4'd8) ? ST_ALO : ST_WLO;
               end
               ST_ALO: step_in = ST_AHI;
               ST_AHI: begin
                  if (byte_idx_in == 2'd0) begin
                     byte_idx_in = 2'd1;
                     tx_in       = byte_for(2'd1, lat_op_in, lat_dev_in, lat_reg_in,
                                            lat_data_in);
                     bit_cnt_in  = '0;
                     step_in     = ST_WLO;
                  end else if (byte_idx_in == 2'd1) begin
                     byte_idx_in = 2'd2;
                     if (lat_op_in == OP_READ) begin
                        step_in = ST_RPREP;
                     end else begin
                        next_byte  = byte_for(2'd2, lat_op_in, lat_dev_in, lat_reg_in,
                                              lat_data_in);
                        tx_in      = next_byte;
                        bit_cnt_in = '0;
                        step_in    = ST_WLO;
                     end
                  end else if (lat_op_in == OP_READ) begin
                     rx_in      = '0;
                     bit_cnt_in = '0;
                     step_in    = ST_RLO;
                  end else begin
                     step_in = ST_PA;
                  end
               end
               ST_RPREP: step_in = ST_SHI;
               ST_RLO:   step_in = ST_RHI;
               ST_RHI: begin
                  rx_in      = {rx_in[6:0], in_item.sda_in};
                  bit_cnt_in = bit_cnt_in + 1'b1;
                  step_in    = (bit_cnt_in >= 4'd8) ? ST_NLO : ST_RLO;
               end
               ST_NLO: step_in = ST_NHI;
               ST_NHI: step_in = ST_PA;
               ST_PA:  step_in = ST_PB;
               ST_PB:  step_in = ST_PC;
               default: begin
                  step_in     = ST_IDLE;
                  bit_cnt_in  = '0;
                  byte_idx_in = '0;
                  done        = 1'b1;
               end
            endcase
         end else begin
            tick_in = tick_in + 1'b1;
         end
      end

      out_item.scl       = pins[2];
      out_item.sda_oe    = pins[0];
      out_item.sda_out   = pins[0] ? pins[1] : 1'b1;
      out_item.busy_res  = busy;
      out_item.done_res  = done;
      out_item.read_data = rx_in;
   end

   // Sequencer state, advanced once per request taken
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff     <= ST_IDLE;
         bit_cnt_ff  <= '0;
         byte_idx_ff <= '0;
         tx_ff       <= '0;
         rx_ff       <= '0;
         tick_ff     <= '0;
         lat_op_ff   <= '0;
         lat_dev_ff  <= '0;
         lat_reg_ff  <= '0;
         lat_data_ff <= '0;
      end else if (take) begin
         step_ff     <= step_in;
         bit_cnt_ff  <= bit_cnt_in;
         byte_idx_ff <= byte_idx_in;
         tx_ff       <= tx_in;
         rx_ff       <= rx_in;
         tick_ff     <= tick_in;
         lat_op_ff   <= lat_op_in;
         lat_dev_ff  <= lat_dev_in;
         lat_reg_ff  <= lat_reg_in;
         lat_data_ff <= lat_data_in;
      end
   end

   // Phase length register
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= TICKS_PER_PHASE_RESET;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

endmodule

// ===== sv/i2c_register_access_master.sv =====
// Requests are registered in the request queue; the sequencer computes each result
// combinationally from the queue head and writes it straight into the result queue.
// Throughput: one request per cycle, stepping one tick each, while the result queue has room.
// Both queues hold QUEUE_DEPTH entries, so either side may stall alone.
// Reset (synchronous, active high) empties both queues, returns the
// sequencer to idle and sets the phase length to 16 ticks.
module i2c_register_access_master #(
   parameter int QUEUE_DEPTH = i2cram_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_start_req,
   input  logic        req_op,
   input  logic [6:0]  req_device_id,
   input  logic [7:0]  req_reg_addr,
   input  logic [7:0]  req_wr_data,
   input  logic        req_sda_in,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_scl,
   output logic        rsp_sda_out,
   output logic        rsp_sda_oe,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_read_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import i2cram_pkg::*;

   req_item_type req_item, head_item;
   rsp_item_type seq_item, rsp_item;
   logic         inq_empty, outq_full, seq_take;

   assign req_item = '{start_req: req_start_req, op: req_op, device_id: req_device_id,
                       reg_addr: req_reg_addr, wr_data: req_wr_data, sda_in: req_sda_in};

   // Front: request queue
   i2cram_fifo #(.WIDTH($bits(req_item_type)), .DEPTH(QUEUE_DEPTH)) u_req_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (req_item),
      .pop     (seq_take),
      .empty   (inq_empty),
      .rd_data (head_item)
   );

   // Back: pin sequencer
   i2cram_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_empty    (inq_empty),
      .in_item     (head_item),
      .out_full    (outq_full),
      .take        (seq_take),
      .out_item    (seq_item)
   );

   // Result queue
   i2cram_fifo #(.WIDTH($bits(rsp_item_type)), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (seq_take),
      .full    (outq_full),
      .wr_data (seq_item),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_item)
   );

   assign rsp_scl       = rsp_item.scl;
   assign rsp_sda_out   = rsp_item.sda_out;
   assign rsp_sda_oe    = rsp_item.sda_oe;
   assign rsp_busy_res  = rsp_item.busy_res;
   assign rsp_done_res  = rsp_item.done_res;
   assign rsp_read_data = rsp_item.read_data;

   // Sequencer never steps without room for its result
   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      outq_full |-> !seq_take) else $error("sequencer stepped into a full result queue");

   // A finishing tick is always a busy tick
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (seq_take && seq_item.done_res) |-> seq_item.busy_res)
      else $error("done raised outside a transfer");

   // Released data line reads back high
   a_release_high: assert property (@(posedge clock) disable iff (reset)
      (seq_take && !seq_item.sda_oe) |-> seq_item.sda_out)
      else $error("data line low while released");

endmodule

// ===== sim/tb_i2c_register_access_master.sv =====
// Testbench for the I2C register access master: tick-accurate prediction of pins and status.
`timescale 1ns / 1ps

module tb_i2c_register_access_master;
   import i2cram_pkg::*;

   // Pin steps in one write and one read transfer
   localparam int WRITE_STEPS = 59;
   localparam int READ_STEPS  = 80;
   // Data line fill for the ticks of a transfer
   localparam int SDA_RANDOM = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_LOW    = 2;
   // Watchdog and long receiver hold
   localparam int STUCK_LIMIT = 2000;
   localparam int LONG_HOLD   = 64;
   localparam int HOLD_AFTER  = 300;
   localparam int PRINT_CAP   = 40;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_START_HI, SEQ_START_LO, SEQ_BIT_LO, SEQ_BIT_HI, SEQ_ACK_LO,
      SEQ_ACK_HI, SEQ_RESTART_PREP, SEQ_RD_LO, SEQ_RD_HI, SEQ_NACK_LO, SEQ_NACK_HI,
      SEQ_STOP_A, SEQ_STOP_B, SEQ_STOP_C
   } seq_step_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_start_req = 1'b0;
   logic        req_op = 1'b0;
   logic [6:0]  req_device_id = '0;
   logic [7:0]  req_reg_addr = '0;
   logic [7:0]  req_wr_data = '0;
   logic        req_sda_in = 1'b1;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic        rsp_scl;
   logic        rsp_sda_out;
   logic        rsp_sda_oe;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [7:0]  rsp_read_data;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   // Requests waiting to be sent and bus ticks still to come back
   req_item_type ticks_to_send[$];
   rsp_item_type ticks_due[$];

   // Sequencer mirror
   seq_step_type seq_step;
   logic [3:0]  bit_cnt;
   logic [1:0]  byte_idx;
   logic [7:0]  tx_byte;
   logic [7:0]  rx_byte;
   logic [15:0] tick_cnt;
   logic        lat_op;
   logic [6:0]  lat_dev;
   logic [7:0]  lat_addr;
   logic [7:0]  lat_data;
   logic [2:0]  line_levels;
   logic [15:0] phase_len;

   logic quiet_tail = 1'b0;
   int   err_count = 0;
   int   stuck_cycles = 0;
   int   send_gap = 0;
   int   pop_gap = 0;
   int   hold_left = 0;
   int   pops_taken = 0;
   bit   long_hold_done = 1'b0;

   i2c_register_access_master dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_start_req (req_start_req),
      .req_op        (req_op),
      .req_device_id (req_device_id),
      .req_reg_addr  (req_reg_addr),
      .req_wr_data   (req_wr_data),
      .req_sda_in    (req_sda_in),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_scl       (rsp_scl),
      .rsp_sda_out   (rsp_sda_out),
      .rsp_sda_oe    (rsp_sda_oe),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_read_data (rsp_read_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic flag_error(input string msg);
      if (err_count < PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
      err_count++;
   endtask

   // Pin levels {scl, sda, oe} held during a step
   function automatic logic [2:0] levels_for(input seq_step_type s);
      case (s)
         SEQ_START_HI:     return 3'b111;
         SEQ_START_LO:     return 3'b101;
         SEQ_BIT_LO:       return {1'b0, tx_byte[7], 1'b1};
         SEQ_BIT_HI:       return {1'b1, tx_byte[7], 1'b1};
         SEQ_ACK_LO:       return 3'b010;
         SEQ_ACK_HI:       return 3'b110;
         SEQ_RESTART_PREP: return 3'b011;
         SEQ_RD_LO:        return 3'b010;
         SEQ_RD_HI:        return 3'b110;
         SEQ_NACK_LO:      return 3'b011;
         SEQ_NACK_HI:      return 3'b111;
         SEQ_STOP_A:       return 3'b001;
         SEQ_STOP_B:       return 3'b101;
         SEQ_STOP_C:       return 3'b111;
         default:          return line_levels;
      endcase
   endfunction

   // Device byte, register byte, then data byte or device byte with read bit
   task automatic load_tx_byte();
      case (byte_idx)
         2'd0:    tx_byte = {lat_dev, 1'b0};
         2'd1:    tx_byte = lat_addr;
         default: tx_byte = (lat_op == OP_READ) ? {lat_dev, 1'b1} : lat_data;
      endcase
      bit_cnt  = '0;
      seq_step = SEQ_BIT_LO;
   endtask

   // Move on at the last tick of a step; finished is set at the end of the stop
   task automatic end_of_step(input logic sda, output logic finished);
      finished = 1'b0;
      case (seq_step)
         SEQ_START_HI: seq_step = SEQ_START_LO;
         SEQ_START_LO: load_tx_byte();
         SEQ_BIT_LO:   seq_step = SEQ_BIT_HI;
         SEQ_BIT_HI: begin
            tx_byte  = tx_byte << 1;
            bit_cnt  = bit_cnt + 4'd1;
            seq_step = (bit_cnt >= 4'd8) ? SEQ_ACK_LO : SEQ_BIT_LO;
         end
         SEQ_ACK_LO:   seq_step = SEQ_ACK_HI;
         SEQ_ACK_HI: begin
            if (byte_idx == 2'd0) begin
               byte_idx = 2'd1;
               load_tx_byte();
            end else if (byte_idx == 2'd1) begin
               byte_idx = 2'd2;
               if (lat_op == OP_READ) seq_step = SEQ_RESTART_PREP;
               else load_tx_byte();
            end else if (lat_op == OP_READ) begin
               rx_byte  = '0;
               bit_cnt  = '0;
               seq_step = SEQ_RD_LO;
            end else begin
               seq_step = SEQ_STOP_A;
            end
         end
         SEQ_RESTART_PREP: seq_step = SEQ_START_HI;
         SEQ_RD_LO:    seq_step = SEQ_RD_HI;
         SEQ_RD_HI: begin
            rx_byte  = {rx_byte[6:0], sda};
            bit_cnt  = bit_cnt + 4'd1;
            seq_step = (bit_cnt >= 4'd8) ? SEQ_NACK_LO : SEQ_RD_LO;
         end
         SEQ_NACK_LO:  seq_step = SEQ_NACK_HI;
         SEQ_NACK_HI:  seq_step = SEQ_STOP_A;
         SEQ_STOP_A:   seq_step = SEQ_STOP_B;
         SEQ_STOP_B:   seq_step = SEQ_STOP_C;
         default: begin
            seq_step = SEQ_IDLE;
            bit_cnt  = '0;
            byte_idx = '0;
            finished = 1'b1;
         end
      endcase
   endtask

   // One bus tick: latch a request when idle, drive the step's pins, count the tick
   task automatic predict_bus_tick(input req_item_type r);
      logic [16:0]  period;
      logic [2:0]   lv;
      logic         finished;
      rsp_item_type e;
      period   = (phase_len == 16'd0) ? 17'd1 : {1'b0, phase_len};
      finished = 1'b0;
      if (seq_step == SEQ_IDLE && r.start_req) begin
         lat_op   = r.op;
         lat_dev  = r.device_id;
         lat_addr = r.reg_addr;
         lat_data = r.wr_data;
         seq_step = SEQ_START_HI;
         tick_cnt = '0;
         byte_idx = '0;
         bit_cnt  = '0;
      end
      e.busy_res  = (seq_step != SEQ_IDLE);
      lv          = levels_for(seq_step);
      line_levels = lv;
      if (e.busy_res) begin
         if ({1'b0, tick_cnt} + 17'd1 >= period) begin
            tick_cnt = '0;
            end_of_step(r.sda_in, finished);
         end else begin
            tick_cnt = tick_cnt + 16'd1;
         end
      end
      e.scl       = lv[2];
      e.sda_oe    = lv[0];
      e.sda_out   = lv[0] ? lv[1] : 1'b1;
      e.done_res  = finished;
      e.read_data = rx_byte;
      ticks_due.push_back(e);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_push    <= 1'b0;
         send_gap    = 0;
         seq_step    = SEQ_IDLE;
         bit_cnt     = '0;
         byte_idx    = '0;
         tx_byte     = '0;
         rx_byte     = '0;
         tick_cnt    = '0;
         lat_op      = OP_WRITE;
         lat_dev     = '0;
         lat_addr    = '0;
         lat_data    = '0;
         line_levels = 3'b111;
         phase_len   = TICKS_PER_PHASE_RESET;
      end else begin
         if (req_push && !req_full) begin
            predict_bus_tick(ticks_to_send[0]);
            void'(ticks_to_send.pop_front());
         end
         if (send_gap == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 4);
         if (send_gap > 0 || ticks_to_send.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_push <= 1'b0;
         end else begin
            req_push      <= 1'b1;
            req_start_req <= ticks_to_send[0].start_req;
            req_op        <= ticks_to_send[0].op;
            req_device_id <= ticks_to_send[0].device_id;
            req_reg_addr  <= ticks_to_send[0].reg_addr;
            req_wr_data   <= ticks_to_send[0].wr_data;
            req_sda_in    <= ticks_to_send[0].sda_in;
         end
      end
   end

   // Result pop: short random stalls, one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) pops_taken++;
         if (!long_hold_done && pops_taken >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD;
         end
         if (pop_gap == 0 && !quiet_tail && $urandom_range(0, 7) == 0)
            pop_gap = $urandom_range(1, 4);
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (ticks_due.size() == 0) begin
            flag_error("result with nothing expected");
         end else begin
            want = ticks_due.pop_front();
            if (rsp_scl !== want.scl)
               flag_error($sformatf("scl got %b want %b", rsp_scl, want.scl));
            if (rsp_sda_out !== want.sda_out)
               flag_error($sformatf("sda_out got %b want %b", rsp_sda_out, want.sda_out));
            if (rsp_sda_oe !== want.sda_oe)
               flag_error($sformatf("sda_oe got %b want %b", rsp_sda_oe, want.sda_oe));
            if (rsp_busy_res !== want.busy_res)
               flag_error($sformatf("busy got %b want %b", rsp_busy_res, want.busy_res));
            if (rsp_done_res !== want.done_res)
               flag_error($sformatf("done got %b want %b", rsp_done_res, want.done_res));
            if (rsp_read_data !== want.read_data)
               flag_error($sformatf("read_data got %h want %h", rsp_read_data,
                                    want.read_data));
         end
      end
   end

   // Watchdog: cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Ticks with random operands; may_start lets busy-time requests through
   task automatic queue_filler(input int n, input bit may_start, input int sda_fill);
      req_item_type t;
      for (int i = 0; i < n; i++) begin
         t.start_req = may_start ? 1'($urandom_range(0, 1)) : 1'b0;
         t.op        = 1'($urandom_range(0, 1));
         t.device_id = 7'($urandom);
         t.reg_addr  = 8'($urandom);
         t.wr_data   = 8'($urandom);
         case (sda_fill)
            SDA_HIGH: t.sda_in = 1'b1;
            SDA_LOW:  t.sda_in = 1'b0;
            default:  t.sda_in = 1'($urandom_range(0, 1));
         endcase
         ticks_to_send.push_back(t);
      end
   endtask

   function automatic int transfer_ticks(input logic op);
      int eff;
      eff = (phase_len == 16'd0) ? 1 : int'(phase_len);
      return ((op == OP_READ) ? READ_STEPS : WRITE_STEPS) * eff;
   endfunction

   // A start request followed by every tick of its transfer
   task automatic queue_transfer(input logic op, input logic [6:0] dev,
                                 input logic [7:0] addr, input logic [7:0] data,
                                 input int sda_fill);
      req_item_type t;
      t.start_req = 1'b1;
      t.op        = op;
      t.device_id = dev;
      t.reg_addr  = addr;
      t.wr_data   = data;
      t.sda_in    = 1'($urandom_range(0, 1));
      ticks_to_send.push_back(t);
      queue_filler(transfer_ticks(op) - 1, 1'b1, sda_fill);
   endtask

   task automatic wait_drained();
      while (ticks_to_send.size() != 0 || ticks_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_phase_len(input logic [15:0] v);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      phase_len   = v;
   endtask

   // Random transfers with idle gaps, one sender pause halfway
   task automatic run_random(input int budget);
      int    n;
      int    gap;
      int    pick;
      logic  op;
      bit    paused;
      n      = 0;
      paused = 1'b0;
      while (n < budget) begin
         gap = $urandom_range(0, 3);
         queue_filler(gap, 1'b0, SDA_RANDOM);
         op   = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 5);
         queue_transfer(op, 7'($urandom), 8'($urandom), 8'($urandom),
                        (pick == 0) ? SDA_HIGH : (pick == 1) ? SDA_LOW : SDA_RANDOM);
         n += gap + transfer_ticks(op);
         if (!paused && n >= budget / 2) begin
            paused = 1'b1;
            wait_drained();
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset step length: only the opening steps of a write, each step at the reset phase length
      queue_filler(2, 1'b0, SDA_RANDOM);
      ticks_to_send.push_back('{start_req: 1'b1, op: OP_WRITE, device_id: 7'h5A,
                                reg_addr: 8'hC3, wr_data: 8'h96, sda_in: 1'b1});
      queue_filler(40, 1'b0, SDA_RANDOM);

      // Directed: operand extremes, both operations, read data all ones and all zeros,
      // back-to-back transfers
      set_phase_len(16'd1);
      queue_filler(60, 1'b0, SDA_RANDOM);
      queue_transfer(OP_WRITE, 7'h7F, 8'hFF, 8'hFF, SDA_HIGH);
      queue_transfer(OP_WRITE, 7'h00, 8'h00, 8'h00, SDA_LOW);
      queue_transfer(OP_READ, 7'h7F, 8'hFF, 8'hFF, SDA_HIGH);
      queue_transfer(OP_READ, 7'h00, 8'h00, 8'h00, SDA_LOW);
      queue_filler(3, 1'b0, SDA_RANDOM);
      queue_transfer(OP_READ, 7'h2A, 8'h5A, 8'hA5, SDA_RANDOM);
      queue_transfer(OP_WRITE, 7'h55, 8'hAA, 8'h5A, SDA_RANDOM);
      queue_filler(2, 1'b0, SDA_RANDOM);

      run_random(100);
      // Zero step length behaves as one tick
      set_phase_len(16'd0);
      run_random(40);
      set_phase_len(16'd2);
      run_random(80);

      // Last part: no idling on either side
      wait_drained();
      @(posedge clock);
      quiet_tail <= 1'b1;
      set_phase_len(16'd3);
      run_random(80);

      // Longest step: a read that only gets under way
      set_phase_len(16'hFFFF);
      queue_transfer_head: begin
         queue_filler(1, 1'b0, SDA_RANDOM);
         ticks_to_send.push_back('{start_req: 1'b1, op: OP_READ, device_id: 7'h3C,
                                   reg_addr: 8'h81, wr_data: 8'h7E, sda_in: 1'b1});
         queue_filler(50, 1'b1, SDA_RANDOM);
      end

      wait_drained();
      repeat (6) @(posedge clock);
      if (err_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
